// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tss_pkg.sv -----
// Shared types and constants for the touch setting stepper.
// No dependencies.
package tss_pkg;

    localparam logic [5:0]  INITIAL_SETTING = 6'd24;
    localparam logic [7:0]  SCREEN_RIGHT    = 8'd249;
    localparam logic [7:0]  PLUS_TOP        = 8'd1;
    localparam logic [7:0]  MINUS_BOTTOM    = 8'd122;
    localparam logic [11:0] CNT_MAX         = 12'hFFF;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS = 3'd0,
        REG_COMMIT_TICKS   = 3'd1,
        REG_SETTING_MIN    = 3'd2,
        REG_SETTING_MAX    = 3'd3,
        REG_COLUMN_LEFT    = 3'd4,
        REG_PLUS_BOTTOM    = 3'd5,
        REG_MINUS_TOP      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] debounce_ticks;
        logic [11:0] commit_ticks;
        logic [5:0]  setting_min;
        logic [5:0]  setting_max;
        logic [7:0]  column_left;
        logic [7:0]  plus_bottom;
        logic [7:0]  minus_top;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] touch_x;
        logic [7:0] touch_y;
    } item_t;

    typedef struct packed {
        logic [5:0] setting;
        logic       pending;
        logic       adjusted;
        logic       commit;
    } result_t;

endpackage

// ----- src/tss_cfg.sv -----
// Configuration register file for the touch setting stepper.
// Depends on tss_pkg.
module tss_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tss_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]  wr_data,
    output tss_pkg::cfg_t                   cfg
);
    import tss_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= 12'd300;
            cfg_reg.commit_ticks   <= 12'd800;
            cfg_reg.setting_min    <= 6'd10;
            cfg_reg.setting_max    <= 6'd50;
            cfg_reg.column_left    <= 8'd183;
            cfg_reg.plus_bottom    <= 8'd38;
            cfg_reg.minus_top      <= 8'd83;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= wr_data[11:0];
                REG_COMMIT_TICKS:   cfg_reg.commit_ticks   <= wr_data[11:0];
                REG_SETTING_MIN:    cfg_reg.setting_min    <= wr_data[5:0];
                REG_SETTING_MAX:    cfg_reg.setting_max    <= wr_data[5:0];
                REG_COLUMN_LEFT:    cfg_reg.column_left    <= wr_data[7:0];
                REG_PLUS_BOTTOM:    cfg_reg.plus_bottom    <= wr_data[7:0];
                REG_MINUS_TOP:      cfg_reg.minus_top      <= wr_data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/tss_core.sv -----
// Setting state, touch decode, step and commit logic, and the result register.
// Depends on tss_pkg.
module tss_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tss_pkg::item_t   item,
    input  tss_pkg::cfg_t    cfg,
    output tss_pkg::result_t result
);
    import tss_pkg::*;

    logic [11:0] since_press_reg,  since_press_next;
    logic [11:0] since_change_reg, since_change_next;
    logic [5:0]  setting_reg,      setting_next;
    logic        pending_reg,      pending_next;
    result_t     result_reg,       result_next;

    logic signed [9:0] screen_x;
    logic              in_column;
    logic              plus_hit;
    logic              minus_hit;
    logic              debounce_ok;
    logic              press;
    logic signed [7:0] stepped;
    logic signed [7:0] clamp_hi;
    logic signed [7:0] clamped;
    logic [11:0]       press_inc;
    logic [11:0]       change_inc;
    logic              commit_now;

    always_comb
    begin
        screen_x  = $signed({2'b00, SCREEN_RIGHT}) - $signed({2'b00, item.touch_y});
        in_column = (screen_x >= $signed({2'b00, cfg.column_left}))
                 && (screen_x <= ($signed({2'b00, SCREEN_RIGHT}) + 10'sd1));
        plus_hit  = (item.touch_x >= PLUS_TOP) && (item.touch_x <= cfg.plus_bottom);
        minus_hit = (item.touch_x >= cfg.minus_top) && (item.touch_x <= MINUS_BOTTOM);
        debounce_ok = since_press_reg >= cfg.debounce_ticks;
        press = item.action && debounce_ok && in_column && (plus_hit || minus_hit);

        // plus wins where the two regions overlap
        if (plus_hit)
            stepped = $signed({2'b00, setting_reg}) + 8'sd1;
        else
            stepped = $signed({2'b00, setting_reg}) - 8'sd1;

        // upper clamp first, then lower
        if (stepped > $signed({2'b00, cfg.setting_max}))
            clamp_hi = $signed({2'b00, cfg.setting_max});
        else
            clamp_hi = stepped;
        if (clamp_hi < $signed({2'b00, cfg.setting_min}))
            clamped = $signed({2'b00, cfg.setting_min});
        else
            clamped = clamp_hi;

        press_inc  = (since_press_reg == CNT_MAX) ? CNT_MAX : since_press_reg + 12'd1;
        change_inc = (since_change_reg == CNT_MAX) ? CNT_MAX : since_change_reg + 12'd1;

        since_press_next  = since_press_reg;
        since_change_next = since_change_reg;
        setting_next      = setting_reg;
        pending_next      = pending_reg;

        if (!item.action)
        begin
            since_press_next  = press_inc;
            since_change_next = change_inc;
        end
        else if (press)
        begin
            setting_next      = clamped[5:0];
            pending_next      = 1'b1;
            since_press_next  = 12'd0;
            since_change_next = 12'd0;
        end

        commit_now = pending_next && (since_change_next >= cfg.commit_ticks);
        if (commit_now)
            pending_next = 1'b0;

        result_next.setting  = setting_next;
        result_next.pending  = pending_next;
        result_next.adjusted = press;
        result_next.commit   = commit_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_press_reg  <= CNT_MAX;
            since_change_reg <= CNT_MAX;
            setting_reg      <= INITIAL_SETTING;
            pending_reg      <= 1'b0;
        end
        else if (step)
        begin
            since_press_reg  <= since_press_next;
            since_change_reg <= since_change_next;
            setting_reg      <= setting_next;
            pending_reg      <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- src/touch_setting_stepper.sv -----
// Touch setting stepper: takes one request per clock unless out_ready stalls
// it (a 1 ms tick or a touch report) and returns one result per request. A
// request passes through an input register, and the setting, pending,
// adjusted and commit values then land in the result register as it advances,
// so the sustained rate is one request per cycle, limited only by out_ready.
// Depends on tss_pkg, tss_cfg and tss_core.
module touch_setting_stepper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [7:0]                      touch_x,
    input  logic [7:0]                      touch_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [5:0]                      setting,
    output logic                            pending,
    output logic                            adjusted,
    output logic                            commit
);
    import tss_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    result_t result;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    tss_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action  <= action;
            item_reg.touch_x <= touch_x;
            item_reg.touch_y <= touch_y;
        end
    end

    tss_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign setting   = result.setting;
    assign pending   = result.pending;
    assign adjusted  = result.adjusted;
    assign commit    = result.commit;

endmodule

// ----- src/tss_checker.sv -----
// Port-level checks for the touch setting stepper, bound to the top level.
// Depends on assert_macros.svh and touch_setting_stepper.
`include "assert_macros.svh"

module tss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] setting,
    input logic       pending,
    input logic       adjusted,
    input logic       commit
);

    `ASSERT_IMPLIES(adjust_leaves_change, clk, rst_n, out_valid && adjusted,
        pending || commit, "adjusted result shows neither pending nor commit")

    `ASSERT_IMPLIES(commit_clears_pending, clk, rst_n, out_valid && commit,
        !pending, "commit result still shows pending")

    `ASSERT_NEXT(stalled_result_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(setting) && $stable(pending)
        && $stable(adjusted) && $stable(commit), "stalled result changed")

endmodule

bind touch_setting_stepper tss_checker u_tss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .setting   (setting),
    .pending   (pending),
    .adjusted  (adjusted),
    .commit    (commit)
);
